// File: design/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg: shared types and constants of the video register port
// Request codes, register indexes, field widths and memory sizes used by the
// channel interfaces and the register port.
// ----------------------------------------------------------------------------
package vrp_pkg;

    // field widths of the request and response channels
    localparam int MODE_W = 2;
    localparam int SEL_W  = 3;
    localparam int DATA_W = 8;

    // request kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_READ      = 2'd0,
        MODE_WRITE     = 2'd1,
        MODE_VBLANK    = 2'd2,
        MODE_PRERENDER = 2'd3
    } mode_t;

    // register indexes on the cpu bus
    localparam logic [SEL_W-1:0] REG_CTRL     = 3'd0;
    localparam logic [SEL_W-1:0] REG_MASK     = 3'd1;
    localparam logic [SEL_W-1:0] REG_STATUS   = 3'd2;
    localparam logic [SEL_W-1:0] REG_OAM_ADDR = 3'd3;
    localparam logic [SEL_W-1:0] REG_OAM_DATA = 3'd4;
    localparam logic [SEL_W-1:0] REG_SCROLL   = 3'd5;
    localparam logic [SEL_W-1:0] REG_ADDR     = 3'd6;
    localparam logic [SEL_W-1:0] REG_DATA     = 3'd7;

    // memory sizes
    localparam int NT_BYTES_DEFAULT = 2048;
    localparam int PATTERN_BYTES    = 8192;
    localparam int SPRITE_MEM_BYTES = 256;
    localparam int PALETTE_BYTES    = 32;
    localparam int PAT_AW           = $clog2(PATTERN_BYTES);
    localparam int SPR_AW           = $clog2(SPRITE_MEM_BYTES);
    localparam int PAL_AW           = $clog2(PALETTE_BYTES);

    // video address map, taken to 14 bits
    localparam int               VADDR_W       = 14;
    localparam logic [13:0]      PATTERN_LIMIT = 14'h2000;
    localparam logic [13:0]      PALETTE_BASE  = 14'h3F00;
    localparam logic [DATA_W-1:0] PAL_MASK_GRAY = 8'h30;
    localparam logic [DATA_W-1:0] PAL_MASK_FULL = 8'h3F;

endpackage

// File: design/vrp_req_if.sv
// ----------------------------------------------------------------------------
// vrp_req_if: request channel of the video register port
// Valid/ready channel carrying one bus access or frame event.
// ----------------------------------------------------------------------------
interface vrp_req_if;

    logic                        valid;
    logic                        ready;
    logic [vrp_pkg::MODE_W-1:0]  mode;
    logic [vrp_pkg::SEL_W-1:0]   reg_select;
    logic [vrp_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, output mode, output reg_select, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input reg_select, input write_data,
                    output ready);

endinterface

// File: design/vrp_rsp_if.sv
// ----------------------------------------------------------------------------
// vrp_rsp_if: response channel of the video register port
// Valid/ready channel carrying the read byte and the nmi pulse of a request.
// ----------------------------------------------------------------------------
interface vrp_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [vrp_pkg::DATA_W-1:0]  read_data;
    logic                        nmi_pulse;

    modport source (output valid, output read_data, output nmi_pulse, input ready);
    modport sink   (input valid, input read_data, input nmi_pulse, output ready);

endinterface

// File: design/vrp_ram.sv
// ----------------------------------------------------------------------------
// vrp_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module vrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/video_register_port_and_vram_map.sv
// ----------------------------------------------------------------------------
// video_register_port_and_vram_map: cpu register port of a tile video unit
// Eight bus registers, frame events, sprite memory and the video memory map.
// ----------------------------------------------------------------------------
// After reset the block sweeps all of its memories to zero, one entry per
// cycle, over max(PATTERN_BYTES, NAMETABLE_BYTES) addresses (8192 by default);
// no request is taken during that sweep. After that each request is a
// read-modify-write: when it is taken, the sprite and video memories are read
// at the current addresses; then, once the output register is free or being
// emptied, the read data is used, registers and memories are written back and
// the response is loaded into the output register. A new request is taken
// while a response still waits there, but only after the previous request
// has been executed. Exactly one response is given per request.
// ----------------------------------------------------------------------------
module video_register_port_and_vram_map #(
    parameter int NAMETABLE_BYTES = vrp_pkg::NT_BYTES_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    vrp_req_if.sink   req,
    vrp_rsp_if.source rsp
);

    localparam int NT_AW     = $clog2(NAMETABLE_BYTES);
    localparam int CLR_DEPTH = (vrp_pkg::PATTERN_BYTES > NAMETABLE_BYTES) ?
                               vrp_pkg::PATTERN_BYTES : NAMETABLE_BYTES;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam int DW        = vrp_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    // nametable index, horizontal mirroring
    function automatic logic [10:0] nt_index(input logic [13:0] a);
        nt_index = {a[11], a[9:0]};
    endfunction

    // palette index, backdrop entries alias
    function automatic logic [vrp_pkg::PAL_AW-1:0] pal_index(input logic [13:0] a);
        logic [vrp_pkg::PAL_AW-1:0] idx;
        idx = a[vrp_pkg::PAL_AW-1:0];
        if (idx[4] && (idx[1:0] == 2'b00))
        begin
            idx[4] = 1'b0;
        end
        pal_index = idx;
    endfunction

    state_t              state_reg, state_next;
    logic [CLR_AW-1:0]   clr_cnt_reg, clr_cnt_next;

    logic [DW-1:0]       ctrl_reg, ctrl_next;
    logic [DW-1:0]       mask_reg, mask_next;
    logic [2:0]          status_reg, status_next;
    logic [vrp_pkg::SPR_AW-1:0] oam_addr_reg, oam_addr_next;
    logic [DW-1:0]       rbuf_reg, rbuf_next;
    logic [2:0]          fine_x_reg, fine_x_next;
    logic                toggle_reg, toggle_next;
    logic [15:0]         cur_addr_reg, cur_addr_next;
    logic [15:0]         tmp_addr_reg, tmp_addr_next;

    logic [vrp_pkg::MODE_W-1:0] mode_reg;
    logic [vrp_pkg::SEL_W-1:0]  sel_reg;
    logic [DW-1:0]              wdata_reg;

    logic                out_valid_reg, out_valid_next;
    logic [DW-1:0]       out_rdata_reg, out_rdata_next;
    logic                out_nmi_reg, out_nmi_next;

    logic                accept;
    logic                exec_go;
    logic                clearing;
    logic [13:0]         vaddr;
    logic                in_pattern;
    logic                in_palette;
    logic [15:0]         cur_inc;
    logic [DW-1:0]       vram_rdata;
    logic                vram_wr;

    logic                spr_we, pat_we, nt_we, pal_we;
    logic [vrp_pkg::SPR_AW-1:0] spr_waddr;
    logic [vrp_pkg::PAT_AW-1:0] pat_waddr;
    logic [NT_AW-1:0]           nt_waddr;
    logic [vrp_pkg::PAL_AW-1:0] pal_waddr;
    logic [DW-1:0]       mem_wdata;
    logic [DW-1:0]       spr_rdata, pat_rdata, nt_rdata, pal_rdata;

    // handshake
    assign clearing  = (state_reg == S_CLEAR);
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign exec_go   = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_rdata_reg;
    assign rsp.nmi_pulse = out_nmi_reg;

    // video address decode
    assign vaddr      = cur_addr_reg[13:0];
    assign in_pattern = (vaddr < vrp_pkg::PATTERN_LIMIT);
    assign in_palette = (vaddr >= vrp_pkg::PALETTE_BASE);
    assign cur_inc    = ctrl_reg[2] ? 16'd32 : 16'd1;

    // video memory read data by region
    always_comb
    begin
        if (in_pattern)
        begin
            vram_rdata = pat_rdata;
        end
        else if (!in_palette)
        begin
            vram_rdata = nt_rdata;
        end
        else
        begin
            vram_rdata = pal_rdata & (mask_reg[0] ? vrp_pkg::PAL_MASK_GRAY
                                                  : vrp_pkg::PAL_MASK_FULL);
        end
    end

    // memory write ports: clearing sweep or request write-back
    assign vram_wr = exec_go && (vrp_pkg::mode_t'(mode_reg) == vrp_pkg::MODE_WRITE) &&
                     (sel_reg == vrp_pkg::REG_DATA);

    always_comb
    begin
        if (clearing)
        begin
            spr_we    = 1'b1;
            pat_we    = 1'b1;
            nt_we     = (clr_cnt_reg < CLR_AW'(NAMETABLE_BYTES));
            pal_we    = 1'b1;
            spr_waddr = clr_cnt_reg[vrp_pkg::SPR_AW-1:0];
            pat_waddr = clr_cnt_reg[vrp_pkg::PAT_AW-1:0];
            nt_waddr  = clr_cnt_reg[NT_AW-1:0];
            pal_waddr = clr_cnt_reg[vrp_pkg::PAL_AW-1:0];
            mem_wdata = '0;
        end
        else
        begin
            spr_we    = exec_go && (vrp_pkg::mode_t'(mode_reg) == vrp_pkg::MODE_WRITE) &&
                        (sel_reg == vrp_pkg::REG_OAM_DATA);
            pat_we    = vram_wr && in_pattern;
            nt_we     = vram_wr && !in_pattern && !in_palette;
            pal_we    = vram_wr && in_palette;
            spr_waddr = oam_addr_reg;
            pat_waddr = vaddr[vrp_pkg::PAT_AW-1:0];
            nt_waddr  = NT_AW'(nt_index(vaddr));
            pal_waddr = pal_index(vaddr);
            mem_wdata = wdata_reg;
        end
    end

    // memories
    vrp_ram #(.WIDTH(DW), .DEPTH(vrp_pkg::SPRITE_MEM_BYTES)) u_spr_ram (
        .clk   (clk),
        .we    (spr_we),
        .waddr (spr_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (oam_addr_reg),
        .rdata (spr_rdata)
    );

    vrp_ram #(.WIDTH(DW), .DEPTH(vrp_pkg::PATTERN_BYTES)) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (vaddr[vrp_pkg::PAT_AW-1:0]),
        .rdata (pat_rdata)
    );

    vrp_ram #(.WIDTH(DW), .DEPTH(NAMETABLE_BYTES)) u_nt_ram (
        .clk   (clk),
        .we    (nt_we),
        .waddr (nt_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (NT_AW'(nt_index(vaddr))),
        .rdata (nt_rdata)
    );

    vrp_ram #(.WIDTH(DW), .DEPTH(vrp_pkg::PALETTE_BYTES)) u_pal_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (pal_index(vaddr)),
        .rdata (pal_rdata)
    );

    // sequencer and clearing sweep
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // register update and response
    always_comb
    begin
        ctrl_next      = ctrl_reg;
        mask_next      = mask_reg;
        status_next    = status_reg;
        oam_addr_next  = oam_addr_reg;
        rbuf_next      = rbuf_reg;
        fine_x_next    = fine_x_reg;
        toggle_next    = toggle_reg;
        cur_addr_next  = cur_addr_reg;
        tmp_addr_next  = tmp_addr_reg;
        out_rdata_next = out_rdata_reg;
        out_nmi_next   = out_nmi_reg;
        out_valid_next = out_valid_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (exec_go)
        begin
            out_valid_next = 1'b1;
            out_rdata_next = '0;
            out_nmi_next   = 1'b0;
            unique case (vrp_pkg::mode_t'(mode_reg))
                vrp_pkg::MODE_READ:
                begin
                    case (sel_reg)
                        vrp_pkg::REG_STATUS:
                        begin
                            out_rdata_next = {status_reg, rbuf_reg[4:0]};
                            status_next    = {1'b0, status_reg[1:0]};
                            toggle_next    = 1'b0;
                        end
                        vrp_pkg::REG_OAM_DATA:
                        begin
                            out_rdata_next = spr_rdata;
                        end
                        vrp_pkg::REG_DATA:
                        begin
                            out_rdata_next = in_palette ? vram_rdata : rbuf_reg;
                            rbuf_next      = vram_rdata;
                            cur_addr_next  = cur_addr_reg + cur_inc;
                        end
                        default:
                        begin
                            out_rdata_next = '0;
                        end
                    endcase
                end
                vrp_pkg::MODE_WRITE:
                begin
                    case (sel_reg)
                        vrp_pkg::REG_CTRL:
                        begin
                            ctrl_next            = wdata_reg;
                            tmp_addr_next[11:10] = wdata_reg[1:0];
                        end
                        vrp_pkg::REG_MASK:
                        begin
                            mask_next = wdata_reg;
                        end
                        vrp_pkg::REG_OAM_ADDR:
                        begin
                            oam_addr_next = wdata_reg;
                        end
                        vrp_pkg::REG_OAM_DATA:
                        begin
                            oam_addr_next = oam_addr_reg + 1'b1;
                        end
                        vrp_pkg::REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                fine_x_next        = wdata_reg[2:0];
                                tmp_addr_next[4:0] = wdata_reg[7:3];
                                toggle_next        = 1'b1;
                            end
                            else
                            begin
                                tmp_addr_next[14:12] = wdata_reg[2:0];
                                tmp_addr_next[9:5]   = wdata_reg[7:3];
                                toggle_next          = 1'b0;
                            end
                        end
                        vrp_pkg::REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                tmp_addr_next = {2'b00, wdata_reg[5:0], tmp_addr_reg[7:0]};
                                toggle_next   = 1'b1;
                            end
                            else
                            begin
                                tmp_addr_next = {tmp_addr_reg[15:8], wdata_reg};
                                cur_addr_next = {tmp_addr_reg[15:8], wdata_reg};
                                toggle_next   = 1'b0;
                            end
                        end
                        vrp_pkg::REG_DATA:
                        begin
                            cur_addr_next = cur_addr_reg + cur_inc;
                        end
                        default:
                        begin
                            ctrl_next = ctrl_reg;
                        end
                    endcase
                end
                vrp_pkg::MODE_VBLANK:
                begin
                    status_next[2] = 1'b1;
                    out_nmi_next   = ctrl_reg[7];
                end
                vrp_pkg::MODE_PRERENDER:
                begin
                    status_next = '0;
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    // control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            ctrl_reg      <= '0;
            mask_reg      <= '0;
            status_reg    <= '0;
            oam_addr_reg  <= '0;
            rbuf_reg      <= '0;
            fine_x_reg    <= '0;
            toggle_reg    <= 1'b0;
            cur_addr_reg  <= '0;
            tmp_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            ctrl_reg      <= ctrl_next;
            mask_reg      <= mask_next;
            status_reg    <= status_next;
            oam_addr_reg  <= oam_addr_next;
            rbuf_reg      <= rbuf_next;
            fine_x_reg    <= fine_x_next;
            toggle_reg    <= toggle_next;
            cur_addr_reg  <= cur_addr_next;
            tmp_addr_reg  <= tmp_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= req.mode;
            sel_reg   <= req.reg_select;
            wdata_reg <= req.write_data;
        end
        out_rdata_reg <= out_rdata_next;
        out_nmi_reg   <= out_nmi_next;
    end

`ifndef SYNTHESIS
    // a taken request moves to S_EXEC in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted request not followed by execute");

    // no request is taken while memories are being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req.ready)
        else $error("request ready during clearing sweep");

    // memory reads and write-backs never share a cycle outside the sweep
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(spr_we || pat_we || nt_we || pal_we))
        else $error("memory write during read issue");

    // an nmi response carries no read byte
    a_nmi_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.nmi_pulse) |-> (rsp.read_data == '0))
        else $error("nmi response with nonzero read data");

    // a status read clears the write toggle
    a_status_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && (vrp_pkg::mode_t'(mode_reg) == vrp_pkg::MODE_READ) &&
         (sel_reg == vrp_pkg::REG_STATUS)) |=> !toggle_reg)
        else $error("write toggle not cleared by status read");
`endif

endmodule
